[hdl/obd_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the oriented box decoder
// no dependencies

package obd_pkg;

	localparam int unsigned PI_Q12      = 12868;
	localparam int unsigned HALF_PI_Q12 = 6434;
	localparam int unsigned CORDIC_GAIN = 39797;
	localparam int unsigned ATAN_MAX    = 16;

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_PAD_LEFT  = 3'd1,
		REG_PAD_TOP   = 3'd2,
		REG_INV_SCALE = 3'd3,
		REG_IMG_W     = 3'd4,
		REG_IMG_H     = 3'd5,
		REG_CLASSES   = 3'd6
	} reg_index_t;

	// rotation stage payload
	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [21:0] z;
	} cordic_vec_t;

	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] r;
		case (i)
			4'd0:  r = 17'd51472;
			4'd1:  r = 17'd30386;
			4'd2:  r = 17'd16055;
			4'd3:  r = 17'd8150;
			4'd4:  r = 17'd4091;
			4'd5:  r = 17'd2047;
			4'd6:  r = 17'd1024;
			4'd7:  r = 17'd512;
			4'd8:  r = 17'd256;
			4'd9:  r = 17'd128;
			4'd10: r = 17'd64;
			4'd11: r = 17'd32;
			4'd12: r = 17'd16;
			4'd13: r = 17'd8;
			4'd14: r = 17'd4;
			default: r = 17'd2;
		endcase
		return r;
	endfunction

endpackage

[hdl/obd_cordic_stage.sv]
`timescale 1ns / 1ps
// one registered cordic micro-rotation
// depends on obd_pkg

module obd_cordic_stage #(
	parameter int unsigned STEP = 0
) (
	input  logic                clk,
	input  logic                en,
	input  obd_pkg::cordic_vec_t d,
	output obd_pkg::cordic_vec_t q
);
	import obd_pkg::*;

	cordic_vec_t nxt;
	logic signed [19:0] dx, dy;
	logic signed [21:0] at;

	always_comb begin
		dx = d.y >>> STEP;
		dy = d.x >>> STEP;
		at = $signed({5'd0, atan_q16(4'(STEP))});
		if (!d.z[21]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[hdl/oriented_box_decode_unit.sv]
`timescale 1ns / 1ps
// oriented box decoder: class pick, letterbox undo, angle fold, cordic, corners
// depends on obd_pkg and obd_cordic_stage
// an accepted item passes stages 1 to 4, the cordic chain and stages 5 to 7 before result valid
// throughput: one item per cycle; stall freezes the whole pipeline in place
// a dropped candidate leaves a bubble and produces no result
// arst_n clears valid bits and restores register reset values

module oriented_box_decode_unit #(
	parameter int unsigned MAX_CLASSES  = 4,
	parameter int unsigned CORDIC_STEPS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] center_x,
	input  logic signed [15:0] center_y,
	input  logic signed [15:0] box_width,
	input  logic signed [15:0] box_height,
	input  logic signed [15:0] angle_raw,
	input  logic [15:0]        score_0,
	input  logic [15:0]        score_1,
	input  logic [15:0]        score_2,
	input  logic [15:0]        score_3,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         class_index,
	output logic [15:0]        confidence,
	output logic [15:0]        corner0_x,
	output logic [15:0]        corner0_y,
	output logic [15:0]        corner1_x,
	output logic [15:0]        corner1_y,
	output logic [15:0]        corner2_x,
	output logic [15:0]        corner2_y,
	output logic [15:0]        corner3_x,
	output logic [15:0]        corner3_y
);
	import obd_pkg::*;

	localparam int unsigned NSTEP = (CORDIC_STEPS > ATAN_MAX) ? ATAN_MAX : CORDIC_STEPS;
	localparam int unsigned NCLS  = (MAX_CLASSES > 4) ? 4 : MAX_CLASSES;

	logic [15:0] thr_q, padl_q, padt_q, invs_q;
	logic [12:0] imgw_q, imgh_q;
	logic [2:0]  ncls_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 16'd16384;
			padl_q <= 16'd0;
			padt_q <= 16'd0;
			invs_q <= 16'd4096;
			imgw_q <= 13'd640;
			imgh_q <= 13'd640;
			ncls_q <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_THRESHOLD: thr_q  <= cfg_data;
				REG_PAD_LEFT:  padl_q <= cfg_data;
				REG_PAD_TOP:   padt_q <= cfg_data;
				REG_INV_SCALE: invs_q <= cfg_data;
				REG_IMG_W:     imgw_q <= cfg_data[12:0];
				REG_IMG_H:     imgh_q <= cfg_data[12:0];
				REG_CLASSES:   ncls_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output holds a result that is stalled
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: class pick, padding removal
	logic [2:0]  n_eff;
	logic [15:0] sc [4];
	logic [15:0] best_sc;
	logic [1:0]  best_ix;
	always_comb begin
		sc[0] = score_0; sc[1] = score_1; sc[2] = score_2; sc[3] = score_3;
		n_eff = (ncls_q == 3'd0) ? 3'd1 : ncls_q;
		if (n_eff > 3'(NCLS)) n_eff = 3'(NCLS);
		best_sc = score_0;
		best_ix = 2'd0;
		for (int k = 1; k < 4; k++) begin
			if (3'(k) < n_eff && sc[k] > best_sc) begin
				best_sc = sc[k];
				best_ix = 2'(k);
			end
		end
	end

	logic               v_s1, keep_s1;
	logic [1:0]         cls_s1;
	logic [15:0]        conf_s1;
	logic signed [17:0] dx_s1, dy_s1;
	logic signed [15:0] w_s1, h_s1;
	logic [13:0]        ang_s1;

	// floor mod pi of a 16 bit angle: |a| < 3 pi so at most two corrections
	logic signed [17:0] a0, a1;
	always_comb begin
		a0 = 18'(angle_raw);
		if (a0 < 0) a1 = a0 + 18'(2 * PI_Q12);
		else a1 = a0;
		if (a1 < 0) a1 = a1 + 18'(PI_Q12);
		if (a1 >= 18'(2 * PI_Q12)) a1 = a1 - 18'(2 * PI_Q12);
		else if (a1 >= 18'(PI_Q12)) a1 = a1 - 18'(PI_Q12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s1 <= best_sc > thr_q;
			cls_s1  <= best_ix;
			conf_s1 <= best_sc;
			dx_s1   <= 18'(center_x) - $signed({2'b0, padl_q});
			dy_s1   <= 18'(center_y) - $signed({2'b0, padt_q});
			w_s1    <= box_width;
			h_s1    <= box_height;
			ang_s1  <= a1[13:0];
		end
	end

	// stage 2: scale multiplies
	logic               v_s2, keep_s2;
	logic [1:0]         cls_s2;
	logic [15:0]        conf_s2;
	logic signed [34:0] mx_s2, my_s2, mw_s2, mh_s2;
	logic [13:0]        ang_s2;
	logic signed [16:0] invs_sx;
	assign invs_sx = $signed({1'b0, invs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s2 <= keep_s1;
			cls_s2  <= cls_s1;
			conf_s2 <= conf_s1;
			mx_s2   <= 35'(dx_s1) * 35'(invs_sx);
			my_s2   <= 35'(dy_s1) * 35'(invs_sx);
			mw_s2   <= 35'(w_s1) * 35'(invs_sx);
			mh_s2   <= 35'(h_s1) * 35'(invs_sx);
			ang_s2  <= ang_s1;
		end
	end

	// stage 3: shift, saturate, size check
	function automatic logic signed [17:0] sat18(input logic signed [34:0] m);
		logic signed [22:0] s;
		s = m[34:12];
		if (s > 23'sd131071) return 18'sd131071;
		if (s < -23'sd131072) return -18'sd131072;
		return s[17:0];
	endfunction

	logic               v_s3, keep_s3;
	logic [1:0]         cls_s3;
	logic [15:0]        conf_s3;
	logic signed [17:0] cx_s3, cy_s3, w_s3, h_s3;
	logic [13:0]        ang_s3;
	logic signed [17:0] w_n, h_n;
	assign w_n = sat18(mw_s2);
	assign h_n = sat18(mh_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s3 <= keep_s2 && (w_n > 18'sd16) && (h_n > 18'sd16);
			cls_s3  <= cls_s2;
			conf_s3 <= conf_s2;
			cx_s3   <= sat18(mx_s2);
			cy_s3   <= sat18(my_s2);
			w_s3    <= w_n;
			h_s3    <= h_n;
			ang_s3  <= ang_s2;
		end
	end

	// stage 4: swap, angle fold, cordic start vector
	logic               v_s4, keep_s4, flip_s4;
	logic [1:0]         cls_s4;
	logic [15:0]        conf_s4;
	logic signed [17:0] cx_s4, cy_s4, w_s4, h_s4;
	cordic_vec_t        vec_s4;
	logic [14:0]        ang_sw;
	logic signed [15:0] ang_fold;
	logic               swap, flip;
	always_comb begin
		swap   = w_s3 < h_s3;
		ang_sw = {1'b0, ang_s3};
		if (swap) begin
			ang_sw = ang_sw + 15'(HALF_PI_Q12);
			if (ang_sw >= 15'(PI_Q12)) ang_sw = ang_sw - 15'(PI_Q12);
		end
		flip     = ang_sw > 15'(HALF_PI_Q12);
		ang_fold = flip ? $signed({1'b0, ang_sw}) - 16'sd12868 : $signed({1'b0, ang_sw});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s4 <= keep_s3;
			cls_s4  <= cls_s3;
			conf_s4 <= conf_s3;
			cx_s4   <= cx_s3;
			cy_s4   <= cy_s3;
			w_s4    <= swap ? h_s3 : w_s3;
			h_s4    <= swap ? w_s3 : h_s3;
			flip_s4 <= flip;
			vec_s4.x <= 20'(CORDIC_GAIN);
			vec_s4.y <= '0;
			vec_s4.z <= {{2{ang_fold[15]}}, ang_fold, 4'd0};
		end
	end

	// cordic rotation chain, side data rides in a delay line beside it
	typedef struct packed {
		logic               keep;
		logic               flip;
		logic [1:0]         cls;
		logic [15:0]        conf;
		logic signed [17:0] cx;
		logic signed [17:0] cy;
		logic signed [17:0] w;
		logic signed [17:0] h;
	} side_t;

	cordic_vec_t vec_c [NSTEP + 1];
	side_t       side_c [NSTEP + 1];
	logic        v_c [NSTEP + 1];
	assign vec_c[0]       = vec_s4;
	assign v_c[0]         = v_s4;
	assign side_c[0].keep = keep_s4;
	assign side_c[0].flip = flip_s4;
	assign side_c[0].cls  = cls_s4;
	assign side_c[0].conf = conf_s4;
	assign side_c[0].cx   = cx_s4;
	assign side_c[0].cy   = cy_s4;
	assign side_c[0].w    = w_s4;
	assign side_c[0].h    = h_s4;

	for (genvar g = 0; g < NSTEP; g++) begin : g_rot
		obd_cordic_stage #(.STEP(g)) u_stage (
			.clk(clk), .en(en), .d(vec_c[g]), .q(vec_c[g + 1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_c[g + 1] <= 1'b0;
			else if (en) v_c[g + 1] <= v_c[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_c[g + 1].keep <= side_c[g].keep;
				side_c[g + 1].flip <= side_c[g].flip;
				side_c[g + 1].cls  <= side_c[g].cls;
				side_c[g + 1].conf <= side_c[g].conf;
				side_c[g + 1].cx   <= side_c[g].cx;
				side_c[g + 1].cy   <= side_c[g].cy;
				side_c[g + 1].w    <= side_c[g].w;
				side_c[g + 1].h    <= side_c[g].h;
			end
		end
	end

	// stage 5: half vector products
	logic               v_s5;
	side_t              sd_s5;
	logic signed [38:0] pwc_s5, pws_s5, phs_s5, phc_s5;
	logic signed [20:0] cs, sn;
	always_comb begin
		cs = side_c[NSTEP].flip ? -21'(vec_c[NSTEP].x) : 21'(vec_c[NSTEP].x);
		sn = side_c[NSTEP].flip ? -21'(vec_c[NSTEP].y) : 21'(vec_c[NSTEP].y);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_c[NSTEP];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5.keep <= side_c[NSTEP].keep;
			sd_s5.flip <= side_c[NSTEP].flip;
			sd_s5.cls  <= side_c[NSTEP].cls;
			sd_s5.conf <= side_c[NSTEP].conf;
			sd_s5.cx   <= side_c[NSTEP].cx;
			sd_s5.cy   <= side_c[NSTEP].cy;
			sd_s5.w    <= side_c[NSTEP].w;
			sd_s5.h    <= side_c[NSTEP].h;
			pwc_s5 <= 39'(side_c[NSTEP].w) * 39'(cs);
			pws_s5 <= 39'(side_c[NSTEP].w) * 39'(sn);
			phs_s5 <= 39'(side_c[NSTEP].h) * 39'(sn);
			phc_s5 <= 39'(side_c[NSTEP].h) * 39'(cs);
		end
	end

	// stage 6: corner sums
	logic               v_s6, keep_s6;
	logic [1:0]         cls_s6;
	logic [15:0]        conf_s6;
	logic signed [20:0] px_s6 [4];
	logic signed [20:0] py_s6 [4];
	logic signed [20:0] vxx, vxy, vyx, vyy, cx21, cy21;
	always_comb begin
		vxx  = 21'(pwc_s5 >>> 17);
		vxy  = 21'(pws_s5 >>> 17);
		vyx  = -21'(phs_s5 >>> 17);
		vyy  = 21'(phc_s5 >>> 17);
		cx21 = 21'(sd_s5.cx);
		cy21 = 21'(sd_s5.cy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s6  <= sd_s5.keep;
			cls_s6   <= sd_s5.cls;
			conf_s6  <= sd_s5.conf;
			px_s6[0] <= cx21 + vxx + vyx; py_s6[0] <= cy21 + vxy + vyy;
			px_s6[1] <= cx21 + vxx - vyx; py_s6[1] <= cy21 + vxy - vyy;
			px_s6[2] <= cx21 - vxx - vyx; py_s6[2] <= cy21 - vxy - vyy;
			px_s6[3] <= cx21 - vxx + vyx; py_s6[3] <= cy21 - vxy + vyy;
		end
	end

	// stage 7: clamp to image, output register
	logic [16:0] hi_w, hi_h;
	always_comb begin
		hi_w = (imgw_q == 13'd0) ? 17'd0 : {imgw_q - 13'd1, 4'd0};
		hi_h = (imgh_q == 13'd0) ? 17'd0 : {imgh_q - 13'd1, 4'd0};
		if (hi_w > 17'd65535) hi_w = 17'd65535;
		if (hi_h > 17'd65535) hi_h = 17'd65535;
	end

	function automatic logic [15:0] clampv(input logic signed [20:0] v, input logic [16:0] hi);
		if (v < 0) return 16'd0;
		if (v > $signed({4'd0, hi})) return hi[15:0];
		return v[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s6 && keep_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			class_index <= cls_s6;
			confidence  <= conf_s6;
			corner0_x   <= clampv(px_s6[0], hi_w);
			corner0_y   <= clampv(py_s6[0], hi_h);
			corner1_x   <= clampv(px_s6[1], hi_w);
			corner1_y   <= clampv(py_s6[1], hi_h);
			corner2_x   <= clampv(px_s6[2], hi_w);
			corner2_y   <= clampv(py_s6[2], hi_h);
			corner3_x   <= clampv(px_s6[3], hi_w);
			corner3_y   <= clampv(py_s6[3], hi_h);
		end
	end

`ifndef SYNTHESIS
	a_stall_ties: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(corner0_x) && $stable(confidence)))
		else $error("stalled result changed");
	a_conf_thr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> (keep_s1 == (conf_s1 > thr_q)))
		else $error("keep flag disagrees with threshold");
	a_corner_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, corner2_x} <= hi_w || $past(!en)))
		else $error("corner out of clamp range");
`endif

endmodule

[tb/obd_scoreboard.sv]
`timescale 1ns / 1ps
// checker for the oriented box decoder: watches config, input and result channels,
// predicts each kept candidate and compares results in order; depends on obd_pkg

module obd_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] center_x,
	input  logic signed [15:0] center_y,
	input  logic signed [15:0] box_width,
	input  logic signed [15:0] box_height,
	input  logic signed [15:0] angle_raw,
	input  logic [15:0]        score_0,
	input  logic [15:0]        score_1,
	input  logic [15:0]        score_2,
	input  logic [15:0]        score_3,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         class_index,
	input  logic [15:0]        confidence,
	input  logic [15:0]        corner0_x,
	input  logic [15:0]        corner0_y,
	input  logic [15:0]        corner1_x,
	input  logic [15:0]        corner1_y,
	input  logic [15:0]        corner2_x,
	input  logic [15:0]        corner2_y,
	input  logic [15:0]        corner3_x,
	input  logic [15:0]        corner3_y,
	output int                 fail_count,
	output int                 pending,
	output logic               accepted_any
);
	import obd_pkg::*;

	localparam int MAX_CLASSES  = 4;
	localparam int CORDIC_STEPS = 12;

	typedef struct packed {
		logic [1:0]  cls;
		logic [15:0] conf;
		logic [7:0][15:0] corner;   // x0 y0 x1 y1 x2 y2 x3 y3, index 0 = x0
	} box_t;

	box_t boxes_due[$];

	logic [15:0] thr, pad_l, pad_t, inv_s;
	logic [12:0] img_w, img_h;
	logic [2:0]  n_cls;

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint sat18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic logic [15:0] clamp_to(longint v, logic [12:0] size);
		longint hi;
		hi = (size == 0) ? 0 : (longint'(size) - 1) * 16;
		if (hi > 65535) hi = 65535;
		if (v < 0) return 16'd0;
		if (v > hi) return 16'(hi);
		return 16'(v);
	endfunction

	function automatic longint atan_entry(int i);
		longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return t[i];
	endfunction

	function automatic void rotate(input int ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (ang > HALF_PI_Q12) begin
			ang -= PI_Q12;
			flip = 1;
		end
		z = longint'(ang) * 16;
		for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// returns 1 when the candidate survives, box filled in
	function automatic bit decode_box(output box_t b);
		logic [15:0] sc[4];
		int n, best, ang;
		logic [15:0] best_sc;
		longint cx, cy, w, h, t, c, s, vxx, vxy, vyx, vyy;
		longint px[4], py[4];
		b = '0;
		sc = '{score_0, score_1, score_2, score_3};
		n = n_cls;
		if (n == 0) n = 1;
		if (n > MAX_CLASSES) n = MAX_CLASSES;
		best = 0;
		best_sc = sc[0];
		for (int k = 1; k < n; k++)
			if (sc[k] > best_sc) begin
				best_sc = sc[k];
				best = k;
			end
		if (!(best_sc > thr)) return 0;
		cx = sat18(floor_shift((longint'(center_x) - longint'(pad_l)) * longint'(inv_s), 12));
		cy = sat18(floor_shift((longint'(center_y) - longint'(pad_t)) * longint'(inv_s), 12));
		w = sat18(floor_shift(longint'(box_width) * longint'(inv_s), 12));
		h = sat18(floor_shift(longint'(box_height) * longint'(inv_s), 12));
		if (w <= 16 || h <= 16) return 0;
		ang = int'(angle_raw) % int'(PI_Q12);
		if (ang < 0) ang += PI_Q12;
		if (w < h) begin
			t = w; w = h; h = t;
			ang += HALF_PI_Q12;
			if (ang >= PI_Q12) ang -= PI_Q12;
		end
		rotate(ang, c, s);
		vxx = floor_shift(w * c, 17);
		vxy = floor_shift(w * s, 17);
		vyx = -floor_shift(h * s, 17);
		vyy = floor_shift(h * c, 17);
		px[0] = cx + vxx + vyx; py[0] = cy + vxy + vyy;
		px[1] = cx + vxx - vyx; py[1] = cy + vxy - vyy;
		px[2] = cx - vxx - vyx; py[2] = cy - vxy - vyy;
		px[3] = cx - vxx + vyx; py[3] = cy - vxy + vyy;
		b.cls = 2'(best);
		b.conf = best_sc;
		for (int k = 0; k < 4; k++) begin
			b.corner[2*k]   = clamp_to(px[k], img_w);
			b.corner[2*k+1] = clamp_to(py[k], img_h);
		end
		return 1;
	endfunction

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		box_t b, seen;
		if (!arst_n) begin
			thr <= 16'd16384; pad_l <= '0; pad_t <= '0; inv_s <= 16'd4096;
			img_w <= 13'd640; img_h <= 13'd640; n_cls <= 3'd3;
			accepted_any <= 0;
		end else begin
			accepted_any <= (in_valid && !in_stall) || (out_valid && !out_stall);
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_THRESHOLD: thr <= cfg_data;
					REG_PAD_LEFT:  pad_l <= cfg_data;
					REG_PAD_TOP:   pad_t <= cfg_data;
					REG_INV_SCALE: inv_s <= cfg_data;
					REG_IMG_W:     img_w <= cfg_data[12:0];
					REG_IMG_H:     img_h <= cfg_data[12:0];
					REG_CLASSES:   n_cls <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall && decode_box(b))
				boxes_due.insert(boxes_due.size(), b);
			if (out_valid && !out_stall) begin
				if (boxes_due.size() == 0) begin
					$error("result with no candidate pending");
					fail_count++;
				end else begin
					b = boxes_due.pop_front();
					seen.cls = class_index;
					seen.conf = confidence;
					seen.corner = {corner3_y, corner3_x, corner2_y, corner2_x,
						corner1_y, corner1_x, corner0_y, corner0_x};
					compare_field("class_index", 16'(b.cls), 16'(seen.cls));
					compare_field("confidence", b.conf, seen.conf);
					compare_field("corner0_x", b.corner[0], seen.corner[0]);
					compare_field("corner0_y", b.corner[1], seen.corner[1]);
					compare_field("corner1_x", b.corner[2], seen.corner[2]);
					compare_field("corner1_y", b.corner[3], seen.corner[3]);
					compare_field("corner2_x", b.corner[4], seen.corner[4]);
					compare_field("corner2_y", b.corner[5], seen.corner[5]);
					compare_field("corner3_x", b.corner[6], seen.corner[6]);
					compare_field("corner3_y", b.corner[7], seen.corner[7]);
				end
			end
			pending = boxes_due.size();
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the oriented box decoder
// depends on obd_pkg, oriented_box_decode_unit and obd_scoreboard

module testbench;
	import obd_pkg::*;

	localparam int LATENCY = 12 + 8;
	localparam int WATCHDOG = 5000;

	logic clk, arst_n;
	logic in_valid, in_stall, cfg_valid, cfg_ready, out_valid, out_stall;
	logic signed [15:0] center_x, center_y, box_width, box_height, angle_raw;
	logic [15:0] score_0, score_1, score_2, score_3;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic [1:0]  class_index;
	logic [15:0] confidence;
	logic [15:0] corner0_x, corner0_y, corner1_x, corner1_y;
	logic [15:0] corner2_x, corner2_y, corner3_x, corner3_y;
	int fail_count, pending;
	logic accepted_any;
	int send_idle_pct, recv_stall_pct, quiet_cycles;

	oriented_box_decode_unit i_dut (.*);
	obd_scoreboard i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver side
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	// watchdog on cycles with no accepted item and no config write
	always @(posedge clk) begin
		quiet_cycles = accepted_any || cfg_valid ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(reg_index_t idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_box(logic [15:0] cx, cy, w, h, a, s0, s1, s2, s3);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		center_x <= cx; center_y <= cy; box_width <= w; box_height <= h;
		angle_raw <= a;
		score_0 <= s0; score_1 <= s1; score_2 <= s2; score_3 <= s3;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// mostly plausible boxes with one high score, plus full-range noise
	task automatic send_random();
		logic [15:0] r[9];
		for (int i = 0; i < 9; i++) r[i] = 16'($urandom);
		if ($urandom_range(99) < 75) begin
			r[0] = 16'($urandom_range(0, 11000));
			r[1] = 16'($urandom_range(0, 11000));
			r[2] = 16'($urandom_range(0, 6000));
			r[3] = 16'($urandom_range(0, 6000));
			r[5 + $urandom_range(3)] = 16'($urandom_range(20000, 65535));
		end
		send_box(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0; cfg_valid = 0; out_stall = 0;
		cfg_index = REG_THRESHOLD; cfg_data = 0;
		center_x = 0; center_y = 0; box_width = 0; box_height = 0; angle_raw = 0;
		score_0 = 0; score_1 = 0; score_2 = 0; score_3 = 0;
		send_idle_pct = 11; recv_stall_pct = 56; quiet_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: defaults, ties, extremes of fields, angle folding, size swap
		send_box(16'd3200, 16'd3200, 16'd800, 16'd400, 16'd0, 16'd30000, 16'd30000,
			16'd100, 16'd0);
		send_box(16'd3200, 16'd3200, 16'd400, 16'd800, 16'd3000, 16'd0, 16'd50000,
			16'd50000, 16'd65535);
		send_box(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'd0, 16'd0,
			16'd65535, 16'd0);
		send_box(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'd65535, 16'd0,
			16'd0, 16'd0);
		send_box(16'd100, 16'd100, 16'd16, 16'd500, 16'd6434, 16'd40000, 16'd0, 16'd0, 16'd0);
		send_box(16'd100, 16'd100, 16'd17, 16'd17, 16'd12868, 16'd40000, 16'd0, 16'd0, 16'd0);
		send_box(16'd100, 16'd100, 16'hffff, 16'd500, 16'd6435, 16'd40000, 16'd0, 16'd0, 16'd0);
		send_box(16'd5000, 16'd5000, 16'd900, 16'd900, 16'hcdef, 16'd16384, 16'd16385,
			16'd0, 16'd0);
		send_box(16'd5000, 16'd5000, 16'd900, 16'd300, 16'd9000, 16'd16384, 16'd0,
			16'd0, 16'd0);
		in_valid <= 0;
		drain();

		write_reg(REG_CLASSES, 16'd4);
		write_reg(REG_THRESHOLD, 16'd0);
		send_box(16'd2000, 16'd2000, 16'd600, 16'd200, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd1);
		send_box(16'd2000, 16'd2000, 16'd600, 16'd200, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0);
		in_valid <= 0;
		drain();
		write_reg(REG_INV_SCALE, 16'd0);
		send_box(16'd2000, 16'd2000, 16'd600, 16'd600, 16'd0, 16'd9, 16'd0, 16'd0, 16'd0);
		in_valid <= 0;
		drain();
		write_reg(REG_CLASSES, 16'd0);
		write_reg(REG_INV_SCALE, 16'hffff);
		write_reg(REG_IMG_W, 16'd4096);
		write_reg(REG_IMG_H, 16'd1);
		write_reg(REG_PAD_LEFT, 16'hffff);
		write_reg(REG_PAD_TOP, 16'd1234);
		send_box(16'd3000, 16'd3000, 16'd300, 16'd900, 16'd2000, 16'd5, 16'd9, 16'd9, 16'd9);
		in_valid <= 0;
		drain();

		// random phases with different settings and idling patterns
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin send_idle_pct = 56; recv_stall_pct = 11; end
			if (ph == 6) begin send_idle_pct = 0; recv_stall_pct = 0; end
			case (ph % 3)
				0: begin
					write_reg(REG_THRESHOLD, 16'd16384);
					write_reg(REG_PAD_LEFT, 16'd0);
					write_reg(REG_PAD_TOP, 16'd0);
					write_reg(REG_INV_SCALE, 16'd4096);
					write_reg(REG_IMG_W, 16'd640);
					write_reg(REG_IMG_H, 16'd640);
					write_reg(REG_CLASSES, 16'd3);
				end
				1: begin
					write_reg(REG_THRESHOLD, 16'($urandom_range(0, 30000)));
					write_reg(REG_PAD_LEFT, 16'($urandom_range(0, 2000)));
					write_reg(REG_PAD_TOP, 16'($urandom_range(0, 2000)));
					write_reg(REG_INV_SCALE, 16'($urandom_range(1000, 12000)));
					write_reg(REG_IMG_W, 16'($urandom_range(1, 4096)));
					write_reg(REG_IMG_H, 16'($urandom_range(1, 4096)));
					write_reg(REG_CLASSES, 16'($urandom_range(0, 7)));
				end
				default: begin
					write_reg(REG_THRESHOLD, 16'($urandom));
					write_reg(REG_PAD_LEFT, 16'($urandom));
					write_reg(REG_PAD_TOP, 16'($urandom));
					write_reg(REG_INV_SCALE, 16'($urandom));
					write_reg(REG_IMG_W, 16'($urandom_range(0, 8191)));
					write_reg(REG_IMG_H, 16'($urandom_range(0, 8191)));
					write_reg(REG_CLASSES, 16'($urandom_range(1, 4)));
				end
			endcase
			repeat (100) send_random();
			in_valid <= 0;
			drain();
		end

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
